// ----- src/sdt_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted descending table package
// Shared types and constants of the sorted descending table.
// ----------------------------------------------------------------------------
package sdt_pkg;

   localparam int VALUE_W = 32;
   localparam int CMD_W   = 2;
   localparam int STAT_W  = 2;
   localparam int POS_W   = 4;
   localparam int COUNT_W = 5;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 48;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_DUMP   = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_FULL      = 2'd1,
      STAT_NOT_FOUND = 2'd2,
      STAT_EMPTY     = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_CHK,
      ST_INS_HEAD,
      ST_DEL_RD,
      ST_DEL_CHK,
      ST_DMP_RD,
      ST_DMP_OUT
   } state_type;

endpackage
`default_nettype wire

// ----- src/sdt_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted descending table storage
// Entry memory with one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sdt_ram #(
   parameter int DEPTH = 16
) (
   input  wire logic                                clock,
   input  wire logic                                wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]            wr_addr,
   input  wire logic signed [sdt_pkg::VALUE_W-1:0]  wr_data,
   input  wire logic                                rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]            rd_addr,
   output logic signed [sdt_pkg::VALUE_W-1:0]       rd_data
);
   import sdt_pkg::*;

   logic signed [VALUE_W-1:0] mem [DEPTH];
   logic signed [VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- src/sorted_descending_table.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted descending table
// Holds up to DEPTH signed values in descending order with insert, delete
// and dump commands.
// ----------------------------------------------------------------------------
// The table keeps its entries in one memory with a single read port whose
// data is registered, and works on one command at a time. Each entry visited
// takes a read state, then a state that checks, writes back or emits it. An
// insert walks from the smallest entry toward its slot, moving each smaller
// or equal entry down by one; an insert into an empty or full table answers
// without a walk. A delete scans from the largest entry to the end of the
// table, closing the gap behind the match. A dump emits the entries one at a
// time from the largest, reading each next entry only once the last one is in
// the output register, and waits while the result side is stalled. The next
// command is taken as soon as the previous one has placed its last result in
// the output register.
module sorted_descending_table #(
   parameter int DEPTH = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // [31:0] value
   input  wire logic [sdt_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [1:0] command
   input  wire logic [sdt_pkg::CMD_W-1:0]        req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // [31:0] entry_value, [35:32] entry_position, [40:36] entry_count, zeros
   output logic [sdt_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   // [1:0] status
   output logic [sdt_pkg::STAT_W-1:0]            rsp_tuser,
   output logic                                  rsp_tlast
);
   import sdt_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   state_type                 state_ff, state_in;
   logic [CNT_W-1:0]          occ_ff, occ_in;
   logic [CNT_W-1:0]          idx_ff, idx_in;
   logic signed [VALUE_W-1:0] val_ff, val_in;
   logic                      found_ff, found_in;
   status_type                stat_ff, stat_in;
   logic                      reply_ff, reply_in;

   logic                      rsp_valid_ff;
   logic signed [VALUE_W-1:0] rsp_value_ff;
   logic [POS_W-1:0]          rsp_pos_ff;
   logic [COUNT_W-1:0]        rsp_count_ff;
   status_type                rsp_stat_ff;
   logic                      rsp_last_ff;

   logic                      out_free;
   logic                      out_load;
   logic signed [VALUE_W-1:0] out_value;
   logic [POS_W-1:0]          out_pos;
   logic                      out_last;

   logic                      wr_en;
   logic [IDX_W-1:0]          wr_addr;
   logic signed [VALUE_W-1:0] wr_data;
   logic                      rd_en;
   logic signed [VALUE_W-1:0] rd_data;
   logic                      accept;
   logic                      at_end;

   sdt_ram #(
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (idx_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && !reply_ff;
   assign accept     = req_tvalid && req_tready;
   assign at_end     = (idx_ff == occ_ff - CNT_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         occ_ff   <= '0;
         reply_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         occ_ff   <= occ_in;
         reply_ff <= reply_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      val_ff   <= val_in;
      found_ff <= found_in;
      stat_ff  <= stat_in;
   end

   always_comb begin
      state_in  = state_ff;
      occ_in    = occ_ff;
      idx_in    = idx_ff;
      val_in    = val_ff;
      found_in  = found_ff;
      stat_in   = stat_ff;
      reply_in  = reply_ff;
      wr_en     = 1'b0;
      wr_addr   = '0;
      wr_data   = val_ff;
      rd_en     = 1'b0;
      out_load  = 1'b0;
      out_value = '0;
      out_pos   = '0;
      out_last  = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            if (reply_ff) begin
               if (out_free) begin
                  out_load = 1'b1;
                  reply_in = 1'b0;
               end
            end else if (accept) begin
               val_in   = $signed(req_tdata[VALUE_W-1:0]);
               found_in = 1'b0;
               unique case (cmd_type'(req_tuser))
                  CMD_INSERT: begin
                     if (occ_ff == CNT_W'(DEPTH)) begin
                        stat_in  = STAT_FULL;
                        reply_in = 1'b1;
                     end else if (occ_ff == '0) begin
                        wr_en    = 1'b1;
                        wr_addr  = '0;
                        wr_data  = $signed(req_tdata[VALUE_W-1:0]);
                        occ_in   = CNT_W'(1);
                        stat_in  = STAT_OK;
                        reply_in = 1'b1;
                     end else begin
                        idx_in   = occ_ff - CNT_W'(1);
                        state_in = ST_INS_RD;
                     end
                  end
                  CMD_DELETE: begin
                     if (occ_ff == '0) begin
                        stat_in  = STAT_NOT_FOUND;
                        reply_in = 1'b1;
                     end else begin
                        idx_in   = '0;
                        state_in = ST_DEL_RD;
                     end
                  end
                  CMD_DUMP: begin
                     if (occ_ff == '0) begin
                        stat_in  = STAT_EMPTY;
                        reply_in = 1'b1;
                     end else begin
                        idx_in   = '0;
                        stat_in  = STAT_OK;
                        state_in = ST_DMP_RD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_INS_RD: begin
            rd_en    = 1'b1;
            state_in = ST_INS_CHK;
         end
         ST_INS_CHK: begin
            wr_en   = 1'b1;
            wr_addr = IDX_W'(idx_ff + CNT_W'(1));
            if (val_ff >= rd_data) begin
               wr_data = rd_data;
               if (idx_ff == '0) begin
                  state_in = ST_INS_HEAD;
               end else begin
                  idx_in   = idx_ff - CNT_W'(1);
                  state_in = ST_INS_RD;
               end
            end else begin
               wr_data  = val_ff;
               occ_in   = occ_ff + CNT_W'(1);
               stat_in  = STAT_OK;
               reply_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_INS_HEAD: begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = val_ff;
            occ_in   = occ_ff + CNT_W'(1);
            stat_in  = STAT_OK;
            reply_in = 1'b1;
            state_in = ST_IDLE;
         end
         ST_DEL_RD: begin
            rd_en    = 1'b1;
            state_in = ST_DEL_CHK;
         end
         ST_DEL_CHK: begin
            if (found_ff) begin
               wr_en   = 1'b1;
               wr_addr = IDX_W'(idx_ff - CNT_W'(1));
               wr_data = rd_data;
            end
            found_in = found_ff || (rd_data == val_ff);
            if (at_end) begin
               if (found_in) begin
                  occ_in  = occ_ff - CNT_W'(1);
                  stat_in = STAT_OK;
               end else begin
                  stat_in = STAT_NOT_FOUND;
               end
               reply_in = 1'b1;
               state_in = ST_IDLE;
            end else begin
               idx_in   = idx_ff + CNT_W'(1);
               state_in = ST_DEL_RD;
            end
         end
         ST_DMP_RD: begin
            rd_en    = 1'b1;
            state_in = ST_DMP_OUT;
         end
         ST_DMP_OUT: begin
            if (out_free) begin
               out_load  = 1'b1;
               out_value = rd_data;
               out_pos   = POS_W'(idx_ff);
               out_last  = at_end;
               if (at_end) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + CNT_W'(1);
                  state_in = ST_DMP_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_value_ff <= out_value;
         rsp_pos_ff   <= out_pos;
         rsp_count_ff <= COUNT_W'(occ_ff);
         rsp_stat_ff  <= stat_ff;
         rsp_last_ff  <= out_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_count_ff, rsp_pos_ff, rsp_value_ff};
   assign rsp_tuser  = rsp_stat_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CNT_W'(DEPTH))
      else $error("occupancy exceeds table depth");

   a_occ_step: assert property (@(posedge clock) disable iff (reset)
      !$stable(occ_ff) |-> (occ_ff == $past(occ_ff) + CNT_W'(1)) ||
                           (occ_ff == $past(occ_ff) - CNT_W'(1)))
      else $error("occupancy changed by more than one");

   a_wr_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (CNT_W'(wr_addr) <= occ_ff))
      else $error("write beyond the held entries");

endmodule
`default_nettype wire
